// File: rtl/core/pmam_pkg.sv
// pmam_pkg: shared types and constants for the pace moving average block
// used by pmam_cell, pmam_div and pace_moving_average_minmax; depends on nothing
package pmam_pkg;

    localparam int SPEED_W = 16;
    localparam int CFG_W   = 7;
    localparam int PACE_W  = 27;
    localparam int OUT_W   = 19;
    localparam int FRAC_W  = 8;

    // 3600 s/h * 100 (centi-mph) * 256 (fraction)
    localparam logic [PACE_W-1:0] PACE_NUM      = PACE_W'(92160000);
    localparam logic [PACE_W-1:0] PACE_ALL_ONES = '1;

    // shared divider: 16-bit divisor, two quotient bits per step
    localparam int DIV_W      = 16;
    localparam int RADIX_BITS = 2;
    localparam int DIV_STEPS  = (PACE_W + RADIX_BITS - 1) / RADIX_BITS;
    localparam int DVD_W      = DIV_STEPS * RADIX_BITS;
    localparam int STEP_W     = $clog2(DIV_STEPS);

    typedef struct packed {
        logic              start;
        logic [DVD_W-1:0]  dividend;
        logic [DIV_W-1:0]  rem_init;
        logic [DIV_W-1:0]  divisor;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [PACE_W-1:0] quotient;
    } t_div_rsp;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PACE,
        S_SUB,
        S_ADD,
        S_AVG,
        S_MINMAX,
        S_OUT
    } t_state;

endpackage

// File: rtl/core/pmam_cell.sv
// pmam_cell: one stage of the pace delay line
// depends on pmam_pkg for the pace width
module pmam_cell #(
    parameter int IDX   = 0,
    parameter int IDX_W = 6
) (
    input  logic                        i_clk,
    input  logic                        i_shift,
    input  logic [IDX_W-1:0]            i_len_m1,
    input  logic [pmam_pkg::PACE_W-1:0] i_new,
    input  logic [pmam_pkg::PACE_W-1:0] i_next,
    output logic [pmam_pkg::PACE_W-1:0] o_pace
);

    logic [pmam_pkg::PACE_W-1:0] r_pace;

    // the cell at the window's far end takes the new sample, the rest move down
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_pace <= (i_len_m1 == IDX_W'(IDX)) ? i_new : i_next;
        end
    end

    assign o_pace = r_pace;

endmodule

// File: rtl/core/pmam_div.sv
// pmam_div: iterative restoring divider, two quotient bits per cycle
// depends on pmam_pkg for widths and the request/response structs
module pmam_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  pmam_pkg::t_div_req  i_req,
    output pmam_pkg::t_div_rsp  o_rsp
);

    logic                           r_busy;
    logic                           r_done;
    logic [pmam_pkg::STEP_W-1:0]    r_cnt;
    logic [pmam_pkg::DIV_W:0]       r_rem;
    logic [pmam_pkg::DVD_W-1:0]     r_dvd;
    logic [pmam_pkg::DIV_W-1:0]     r_divisor;

    logic [pmam_pkg::DIV_W:0]       n_rem;
    logic [pmam_pkg::DVD_W-1:0]     n_dvd;
    logic                           w_last;

    assign w_last = (r_cnt == pmam_pkg::STEP_W'(pmam_pkg::DIV_STEPS - 1));

    // quotient bits shift in at the bottom of the dividend register
    always_comb begin
        n_rem = r_rem;
        n_dvd = r_dvd;
        for (int k = 0; k < pmam_pkg::RADIX_BITS; k++) begin
            n_rem = {n_rem[pmam_pkg::DIV_W-1:0], n_dvd[pmam_pkg::DVD_W-1]};
            n_dvd = {n_dvd[pmam_pkg::DVD_W-2:0], 1'b0};
            if (n_rem >= {1'b0, r_divisor}) begin
                n_rem    = n_rem - {1'b0, r_divisor};
                n_dvd[0] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + pmam_pkg::STEP_W'(1);
                if (w_last) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem     <= {1'b0, i_req.rem_init};
            r_dvd     <= pmam_pkg::DVD_W'(i_req.dividend);
            r_divisor <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_dvd <= n_dvd;
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_dvd[pmam_pkg::PACE_W-1:0];

endmodule

// File: rtl/core/pace_moving_average_minmax.sv
// pace_moving_average_minmax: speed samples to pace, moving average, fastest/slowest
// depends on pmam_pkg, pmam_cell and pmam_div

// Each sample transfer is turned into a pace (1/256 s per mile) by a shared
// radix-4 divider, pushed into a delay line of WINDOW_MAX pace cells and added
// to a running sum; once window_len samples are held the sum is divided by the
// window length on the same divider and the fastest and slowest averages are
// updated. One sample is worked on at a time: a nonzero sample takes one pass
// through the divider for its pace and, once the window is full, a second for
// its average; a zero sample skips the first pass. A finished result waits in
// the output register while the next sample is already taken. Writing window_len
// restarts the window and clears fastest and slowest; it needs no clearing pass.
module pace_moving_average_minmax #(
    parameter int WINDOW_MAX = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [pmam_pkg::CFG_W-1:0]    i_cfg_wdata,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [pmam_pkg::SPEED_W-1:0]  i_speed_centi_mph,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_window_full,
    output logic [pmam_pkg::OUT_W-1:0]    o_avg_pace_s,
    output logic [pmam_pkg::OUT_W-1:0]    o_fastest_pace_s,
    output logic [pmam_pkg::OUT_W-1:0]    o_slowest_pace_s,
    output logic                          o_zero_speed
);

    localparam int IDX_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int LEN_W = $clog2(WINDOW_MAX + 1);
    localparam int SUM_W = pmam_pkg::PACE_W + IDX_W;
    localparam int PW    = pmam_pkg::PACE_W;

    pmam_pkg::t_state r_state, n_state;

    logic [LEN_W-1:0]   r_len;
    logic [LEN_W-1:0]   r_fill;
    logic [SUM_W-1:0]   r_sum;
    logic [PW-1:0]      r_fastest;
    logic [PW-1:0]      r_slowest;
    logic [PW-1:0]      r_pace;
    logic [PW-1:0]      r_avg;
    logic               r_zero;
    logic               r_full;

    logic               r_out_valid;
    logic               r_out_full;
    logic [pmam_pkg::OUT_W-1:0] r_out_avg;
    logic [pmam_pkg::OUT_W-1:0] r_out_fast;
    logic [pmam_pkg::OUT_W-1:0] r_out_slow;
    logic               r_out_zero;

    logic               w_accept;
    logic               w_shift;
    logic               w_load_out;
    logic               w_out_space;
    logic               w_is_full;
    logic [LEN_W-1:0]   w_len_eff;
    logic [IDX_W-1:0]   w_len_m1;
    logic [SUM_W-1:0]   w_sum_new;
    logic [PW-1:0]      w_cell [WINDOW_MAX];

    pmam_pkg::t_div_req w_div_req;
    pmam_pkg::t_div_rsp w_div_rsp;

    // window length clamped to 1..WINDOW_MAX
    always_comb begin
        if (i_cfg_wdata == '0) begin
            w_len_eff = LEN_W'(1);
        end else if (int'(i_cfg_wdata) > WINDOW_MAX) begin
            w_len_eff = LEN_W'(WINDOW_MAX);
        end else begin
            w_len_eff = LEN_W'(i_cfg_wdata);
        end
    end

    assign w_len_m1    = IDX_W'(r_len - LEN_W'(1));
    assign w_is_full   = (r_fill >= r_len);
    assign w_sum_new   = r_sum + SUM_W'(r_pace);
    assign w_out_space = !r_out_valid || !i_out_stall;
    assign w_accept    = (r_state == pmam_pkg::S_IDLE) && i_in_valid;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            pmam_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = (i_speed_centi_mph == '0) ? pmam_pkg::S_SUB : pmam_pkg::S_PACE;
                end
            end
            pmam_pkg::S_PACE: begin
                if (w_div_rsp.done) begin
                    n_state = pmam_pkg::S_SUB;
                end
            end
            pmam_pkg::S_SUB: begin
                n_state = pmam_pkg::S_ADD;
            end
            pmam_pkg::S_ADD: begin
                n_state = w_is_full ? pmam_pkg::S_AVG : pmam_pkg::S_OUT;
            end
            pmam_pkg::S_AVG: begin
                if (w_div_rsp.done) begin
                    n_state = pmam_pkg::S_MINMAX;
                end
            end
            pmam_pkg::S_MINMAX: begin
                n_state = pmam_pkg::S_OUT;
            end
            pmam_pkg::S_OUT: begin
                if (w_out_space) begin
                    n_state = pmam_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = pmam_pkg::S_IDLE;
            end
        endcase
    end

    // control strobes and divider requests
    always_comb begin
        w_div_req.start    = 1'b0;
        w_div_req.dividend = pmam_pkg::DVD_W'(pmam_pkg::PACE_NUM);
        w_div_req.rem_init = '0;
        w_div_req.divisor  = i_speed_centi_mph;
        w_shift            = 1'b0;
        w_load_out         = 1'b0;
        case (r_state)
            pmam_pkg::S_IDLE: begin
                w_div_req.start = i_in_valid && (i_speed_centi_mph != '0);
            end
            pmam_pkg::S_SUB: begin
                w_shift = 1'b1;
            end
            pmam_pkg::S_ADD: begin
                // the sum's top bits stay below the length, so they seed the remainder
                w_div_req.start    = w_is_full;
                w_div_req.dividend = w_sum_new[pmam_pkg::DVD_W-1:0];
                w_div_req.rem_init = pmam_pkg::DIV_W'(w_sum_new >> pmam_pkg::DVD_W);
                w_div_req.divisor  = pmam_pkg::DIV_W'(r_len);
            end
            pmam_pkg::S_OUT: begin
                w_load_out = w_out_space;
            end
            default: begin
                w_shift = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pmam_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // window state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len     <= LEN_W'(1);
            r_fill    <= '0;
            r_sum     <= '0;
            r_fastest <= pmam_pkg::PACE_ALL_ONES;
            r_slowest <= '0;
        end else if (i_cfg_we) begin
            r_len     <= w_len_eff;
            r_fill    <= '0;
            r_sum     <= '0;
            r_fastest <= pmam_pkg::PACE_ALL_ONES;
            r_slowest <= '0;
        end else begin
            case (r_state)
                pmam_pkg::S_SUB: begin
                    if (w_is_full) begin
                        r_sum <= r_sum - SUM_W'(w_cell[0]);
                    end else begin
                        r_fill <= r_fill + LEN_W'(1);
                    end
                end
                pmam_pkg::S_ADD: begin
                    r_sum <= w_sum_new;
                end
                pmam_pkg::S_MINMAX: begin
                    if (r_avg < r_fastest) begin
                        r_fastest <= r_avg;
                    end
                    if (r_avg > r_slowest) begin
                        r_slowest <= r_avg;
                    end
                end
                default: begin
                    r_sum <= r_sum;
                end
            endcase
        end
    end

    // per-sample working registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_zero <= (i_speed_centi_mph == '0);
            r_pace <= pmam_pkg::PACE_NUM;
        end
        if ((r_state == pmam_pkg::S_PACE) && w_div_rsp.done) begin
            r_pace <= w_div_rsp.quotient;
        end
        if (r_state == pmam_pkg::S_ADD) begin
            r_full <= w_is_full;
        end
        if ((r_state == pmam_pkg::S_AVG) && w_div_rsp.done) begin
            r_avg <= w_div_rsp.quotient;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out_full <= r_full;
            r_out_zero <= r_zero;
            r_out_avg  <= r_full ? r_avg[PW-1:pmam_pkg::FRAC_W] : '0;
            // no window seen yet: report zero for both extremes
            if (r_fastest == pmam_pkg::PACE_ALL_ONES) begin
                r_out_fast <= '0;
                r_out_slow <= '0;
            end else begin
                r_out_fast <= r_fastest[PW-1:pmam_pkg::FRAC_W];
                r_out_slow <= r_slowest[PW-1:pmam_pkg::FRAC_W];
            end
        end
    end

    pmam_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    for (genvar g = 0; g < WINDOW_MAX; g++) begin : g_cell
        if (g == WINDOW_MAX - 1) begin : g_end
            pmam_cell #(
                .IDX   (g),
                .IDX_W (IDX_W)
            ) u_cell (
                .i_clk    (i_clk),
                .i_shift  (w_shift),
                .i_len_m1 (w_len_m1),
                .i_new    (r_pace),
                .i_next   (r_pace),
                .o_pace   (w_cell[g])
            );
        end else begin : g_mid
            pmam_cell #(
                .IDX   (g),
                .IDX_W (IDX_W)
            ) u_cell (
                .i_clk    (i_clk),
                .i_shift  (w_shift),
                .i_len_m1 (w_len_m1),
                .i_new    (r_pace),
                .i_next   (w_cell[g+1]),
                .o_pace   (w_cell[g])
            );
        end
    end

    assign o_in_stall       = (r_state != pmam_pkg::S_IDLE);
    assign o_out_valid      = r_out_valid;
    assign o_window_full    = r_out_full;
    assign o_avg_pace_s     = r_out_avg;
    assign o_fastest_pace_s = r_out_fast;
    assign o_slowest_pace_s = r_out_slow;
    assign o_zero_speed     = r_out_zero;

endmodule

// File: rtl/core/pmam_checker.sv
// pmam_checker: port-level checks for pace_moving_average_minmax
// depends on pmam_pkg for widths; bound to the top level at the end of this file
module pmam_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          o_in_stall,
    input  logic                          o_out_valid,
    input  logic                          i_out_stall,
    input  logic                          o_window_full,
    input  logic [pmam_pkg::OUT_W-1:0]    o_avg_pace_s,
    input  logic [pmam_pkg::OUT_W-1:0]    o_fastest_pace_s,
    input  logic [pmam_pkg::OUT_W-1:0]    o_slowest_pace_s
);

    // a stalled result stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_avg_pace_s)
            && $stable(o_fastest_pace_s) && $stable(o_slowest_pace_s))
        else $error("result changed while stalled");

    // one sample at a time: the cycle after a transfer the input is stalled
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken on back-to-back cycles");

    a_partial_avg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_window_full |-> o_avg_pace_s == '0)
        else $error("average reported before window filled");

    // current average always lies within the tracked extremes
    a_extremes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_window_full |->
            o_fastest_pace_s <= o_avg_pace_s && o_avg_pace_s <= o_slowest_pace_s)
        else $error("average outside fastest/slowest");

endmodule

bind pace_moving_average_minmax pmam_checker u_pmam_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_in_valid        (i_in_valid),
    .o_in_stall        (o_in_stall),
    .o_out_valid       (o_out_valid),
    .i_out_stall       (i_out_stall),
    .o_window_full     (o_window_full),
    .o_avg_pace_s      (o_avg_pace_s),
    .o_fastest_pace_s  (o_fastest_pace_s),
    .o_slowest_pace_s  (o_slowest_pace_s)
);

// File: tb/tb_pace_moving_average_minmax.sv
// tb_pace_moving_average_minmax: self-checking bench for the pace moving average block
// needs pmam_pkg and the pace_moving_average_minmax rtl; predicts every result in-bench
module tb_pace_moving_average_minmax;

    localparam int SPEED_W = pmam_pkg::SPEED_W;
    localparam int CFG_W   = pmam_pkg::CFG_W;
    localparam int PACE_W  = pmam_pkg::PACE_W;
    localparam int OUT_W   = pmam_pkg::OUT_W;
    localparam int FRAC_W  = pmam_pkg::FRAC_W;
    localparam logic [PACE_W-1:0] PACE_NUM      = pmam_pkg::PACE_NUM;
    localparam logic [PACE_W-1:0] PACE_ALL_ONES = pmam_pkg::PACE_ALL_ONES;

    localparam int WIN_MAX      = 64;
    localparam int LIMIT_CYCLES = 400000;
    localparam int REPORT_MAX   = 10;
    localparam int END_CYCLES   = 50;

    typedef struct packed {
        logic             full;
        logic [OUT_W-1:0] avg_s;
        logic [OUT_W-1:0] fast_s;
        logic [OUT_W-1:0] slow_s;
        logic             zero;
    } t_pace_result;

    logic               i_clk     = 1'b0;
    logic               i_rst_n   = 1'b0;
    logic               cfg_we    = 1'b0;
    logic [CFG_W-1:0]   cfg_wdata = '0;
    logic               in_valid  = 1'b0;
    logic               in_stall;
    logic [SPEED_W-1:0] speed     = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic               window_full;
    logic [OUT_W-1:0]   avg_pace_s;
    logic [OUT_W-1:0]   fastest_pace_s;
    logic [OUT_W-1:0]   slowest_pace_s;
    logic               zero_speed;

    // predictor state
    logic [PACE_W-1:0] hist_pace [WIN_MAX];
    logic [32:0]       pace_total;
    int                hist_slot;
    int                hist_fill;
    logic [PACE_W-1:0] best_avg;
    logic [PACE_W-1:0] worst_avg;
    logic [CFG_W-1:0]  window_len_cfg = CFG_W'(1);

    t_pace_result expected_q [$];

    bit          idle_on = 1'b1;
    int          stall_left = 0;
    int unsigned cycle_count = 0;
    int          mismatches = 0;
    int          samples_sent = 0;
    int          results_seen = 0;
    int          full_seen = 0;
    int          zero_seen = 0;
    int          settings_used = 0;

    pace_moving_average_minmax #(
        .WINDOW_MAX(WIN_MAX)
    ) u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (cfg_we),
        .i_cfg_wdata      (cfg_wdata),
        .i_in_valid       (in_valid),
        .o_in_stall       (in_stall),
        .i_speed_centi_mph(speed),
        .o_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .o_window_full    (window_full),
        .o_avg_pace_s     (avg_pace_s),
        .o_fastest_pace_s (fastest_pace_s),
        .o_slowest_pace_s (slowest_pace_s),
        .o_zero_speed     (zero_speed)
    );

    always #2 i_clk = ~i_clk;

    function automatic void reset_window();
        pace_total = '0;
        hist_slot  = 0;
        hist_fill  = 0;
        best_avg   = PACE_ALL_ONES;
        worst_avg  = '0;
    endfunction

    function automatic t_pace_result predict_pace(input logic [SPEED_W-1:0] spd);
        int                len;
        int                slot;
        logic [PACE_W-1:0] pace;
        logic [PACE_W-1:0] avg;
        t_pace_result      r;
        r   = '0;
        len = int'(window_len_cfg);
        if (len < 1) len = 1;
        if (len > WIN_MAX) len = WIN_MAX;
        if (spd == '0) begin
            pace   = PACE_NUM;
            r.zero = 1'b1;
        end else begin
            pace = PACE_NUM / PACE_W'(spd);
        end
        slot = (hist_slot >= len) ? 0 : hist_slot;
        // once full, the oldest pace in this slot drops out of the sum
        if (hist_fill >= len) pace_total = pace_total - 33'(hist_pace[slot]);
        else hist_fill++;
        hist_pace[slot] = pace;
        pace_total      = pace_total + 33'(pace);
        hist_slot       = (slot + 1 >= len) ? 0 : slot + 1;
        if (hist_fill >= len) begin
            avg     = PACE_W'(pace_total / 33'(len));
            r.full  = 1'b1;
            r.avg_s = OUT_W'(avg >> FRAC_W);
            if (avg < best_avg) best_avg = avg;
            if (avg > worst_avg) worst_avg = avg;
        end
        // fastest and slowest read zero until the first full window
        if (best_avg != PACE_ALL_ONES) begin
            r.fast_s = OUT_W'(best_avg >> FRAC_W);
            r.slow_s = OUT_W'(worst_avg >> FRAC_W);
        end
        return r;
    endfunction

    function automatic logic [SPEED_W-1:0] rand_speed();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2: return SPEED_W'($urandom_range(1, 15));
            3, 4: return SPEED_W'($urandom());
            default: return SPEED_W'($urandom_range(300, 2500));
        endcase
    endfunction

    // one sample transfer, with an optional idle burst before it
    task automatic send_speed(input logic [SPEED_W-1:0] spd);
        int gap;
        gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        speed    <= spd;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
        expected_q.push_back(predict_pace(spd));
        samples_sent++;
        if (spd == '0) zero_seen++;
    endtask

    task automatic wait_results_drained();
        in_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_window_len(input logic [CFG_W-1:0] value);
        wait_results_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge i_clk);
        window_len_cfg = value;
        reset_window();
        settings_used++;
        cfg_we <= 1'b0;
    endtask

    // window_len still at its reset value of one
    task automatic test_reset_window_len();
        send_speed(SPEED_W'(0));
        send_speed(SPEED_W'(65535));
        send_speed(SPEED_W'(1));
        send_speed(SPEED_W'(2));
        send_speed(SPEED_W'(1000));
    endtask

    // partial window, then full windows with zero and extreme speeds mixed in
    task automatic test_window_fill();
        write_window_len(CFG_W'(3));
        send_speed(SPEED_W'(600));
        send_speed(SPEED_W'(1200));
        send_speed(SPEED_W'(0));
        send_speed(SPEED_W'(65535));
        send_speed(SPEED_W'(1));
        send_speed(SPEED_W'(32768));
        send_speed(SPEED_W'(16'h5555));
        send_speed(SPEED_W'(16'hAAAA));
    endtask

    // a length of zero behaves as one
    task automatic test_len_zero();
        write_window_len(CFG_W'(0));
        send_speed(SPEED_W'(800));
        send_speed(SPEED_W'(0));
    endtask

    task automatic test_short_window();
        write_window_len(CFG_W'(2));
        send_speed(SPEED_W'(900));
        send_speed(SPEED_W'(450));
        send_speed(SPEED_W'(1800));
        send_speed(SPEED_W'(700));
    endtask

    task automatic test_random_windows();
        logic [CFG_W-1:0] lens [8];
        int               n;
        int               eff;
        lens[0] = CFG_W'(2);
        lens[1] = CFG_W'(64);
        lens[2] = CFG_W'(7);
        lens[3] = CFG_W'(127);
        lens[4] = CFG_W'(1);
        lens[5] = CFG_W'(33);
        lens[6] = CFG_W'($urandom_range(1, 127));
        lens[7] = CFG_W'(65);
        for (int p = 0; p < 8; p++) begin
            write_window_len(lens[p]);
            eff = (lens[p] == '0) ? 1 : ((int'(lens[p]) > WIN_MAX) ? WIN_MAX : int'(lens[p]));
            n   = eff + $urandom_range(10, 40);
            for (int i = 0; i < n; i++) begin
                // sender holds off mid-window until the pipe is empty
                if (p == 3 && i == n / 2) wait_results_drained();
                send_speed(rand_speed());
            end
        end
    endtask

    // samples offered without gaps, no idling on either side
    task automatic test_steady_stream();
        wait_results_drained();
        idle_on = 1'b0;
        write_window_len(CFG_W'(5));
        for (int i = 0; i < 60; i++) send_speed(rand_speed());
    endtask

    // receiver stall bursts
    always @(posedge i_clk) begin
        if (!idle_on) begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end else if (stall_left > 1) begin
            stall_left <= stall_left - 1;
        end else if (stall_left == 1) begin
            stall_left <= 0;
            out_stall  <= 1'b0;
        end else if ($urandom_range(0, 5) == 0) begin
            out_stall  <= 1'b1;
            stall_left <= $urandom_range(1, 12);
        end
    end

    always @(posedge i_clk) begin
        t_pace_result got;
        t_pace_result want;
        if (i_rst_n && out_valid && !out_stall) begin
            got = {window_full, avg_pace_s, fastest_pace_s, slowest_pace_s, zero_speed};
            results_seen++;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("result %0d arrived with nothing expected", results_seen);
            end else begin
                want = expected_q.pop_front();
                if (want.full) full_seen++;
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display({"result %0d mismatch: expected full=%0d avg=%0d fast=%0d ",
                                  "slow=%0d zero=%0d, got full=%0d avg=%0d fast=%0d ",
                                  "slow=%0d zero=%0d"}, results_seen,
                                 want.full, want.avg_s, want.fast_s, want.slow_s, want.zero,
                                 got.full, got.avg_s, got.fast_s, got.slow_s, got.zero);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_q.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        reset_window();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_window_len();
        test_window_fill();
        test_len_zero();
        test_short_window();
        test_random_windows();
        test_steady_stream();
        wait_results_drained();
        repeat (END_CYCLES) @(posedge i_clk);
        $display("ran %0d speed samples through %0d window lengths plus the reset default",
                 samples_sent, settings_used);
        $display("%0d results checked, %0d from full windows, %0d zero-speed samples",
                 results_seen, full_seen, zero_seen);
        if (mismatches == 0 && expected_q.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("%0d mismatches, %0d results missing", mismatches, expected_q.size());
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
